/* rtl/srtp_pkg.sv */
// Package for the shape record text parser: parse modes, result kinds, characters, helpers.
package srtp_pkg;

  // Width of the decimal accumulators.
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned OUT_WIDTH = 32;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [OUT_WIDTH-1:0] word_t;
  typedef logic [7:0] char_t;

  // Parser modes.
  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_L_TAG   = 4'd2,
    M_C_TAG   = 4'd3,
    M_P_TAG   = 4'd4,
    M_L_FIELD = 4'd5,
    M_C_FIELD = 4'd6,
    M_P_START = 4'd7,
    M_P_FIELD = 4'd8
  } mode_t;

  // Result kinds.
  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Characters the parser reacts to.
  localparam char_t CH_BAR     = 8'h7C;
  localparam char_t CH_SEMI    = 8'h3B;
  localparam char_t CH_COMMA   = 8'h2C;
  localparam char_t CH_HASH    = 8'h23;
  localparam char_t CH_NEWLINE = 8'h0A;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_L_UP    = 8'h4C;
  localparam char_t CH_L_LOW   = 8'h6C;
  localparam char_t CH_C_UP    = 8'h43;
  localparam char_t CH_C_LOW   = 8'h63;
  localparam char_t CH_P_UP    = 8'h50;
  localparam char_t CH_P_LOW   = 8'h70;

  // Field counts of the three record types.
  localparam logic [2:0] LINE_FIELDS   = 3'd4;
  localparam logic [2:0] CIRCLE_FIELDS = 3'd3;
  localparam logic [2:0] POLY_FIELDS   = 3'd2;

  // One result item as it leaves the parser core.
  typedef struct packed {
    logic [1:0] kind;
    word_t      first_x;
    word_t      first_y;
    word_t      second_value;
    word_t      second_y;
    word_t      colour;
    logic       last_point;
  } result_t;

  // Hex digit value; a byte that is no hex letter counts as byte - '0', wrapping.
  function automatic word_t hex_digit(input char_t b);
    word_t d;
    if (b >= 8'h61 && b <= 8'h66) begin
      d = OUT_WIDTH'(b) - OUT_WIDTH'(87);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = OUT_WIDTH'(b) - OUT_WIDTH'(55);
    end else begin
      d = OUT_WIDTH'(b) - OUT_WIDTH'(CH_ZERO);
    end
    return d;
  endfunction

  // Sign-extend or truncate an accumulator to the output word.
  function automatic word_t out_val(input value_t v);
    return OUT_WIDTH'(signed'(v));
  endfunction

endpackage

/* rtl/srtp_core.sv */
// Parser core: record state, accumulators and result decode for one byte per step.
module srtp_core import srtp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  char_t   in_byte,
  output logic    emit,
  output result_t result
);

  mode_t      mode, mode_next;
  logic [2:0] field_index, field_index_next;
  value_t     acc [4];
  value_t     acc_next [4];
  word_t      colour_acc, colour_acc_next;

  logic       clr_pre;
  logic       clr_post;
  logic       fld;
  logic [2:0] ndec;
  logic       last;

  // Next state and result decode.
  always_comb begin
    mode_next = mode;
    clr_pre   = 1'b0;
    clr_post  = 1'b0;
    fld       = 1'b0;
    ndec      = POLY_FIELDS;
    emit      = 1'b0;
    last      = 1'b0;
    result    = '0;

    unique case (mode)
      M_IDLE: begin
        if (in_byte == CH_HASH) begin
          mode_next = M_COMMENT;
        end else if (in_byte == CH_L_UP || in_byte == CH_L_LOW) begin
          clr_pre   = 1'b1;
          mode_next = M_L_TAG;
        end else if (in_byte == CH_C_UP || in_byte == CH_C_LOW) begin
          clr_pre   = 1'b1;
          mode_next = M_C_TAG;
        end else if (in_byte == CH_P_UP || in_byte == CH_P_LOW) begin
          clr_pre   = 1'b1;
          mode_next = M_P_TAG;
        end
      end
      M_COMMENT: begin
        if (in_byte == CH_NEWLINE) mode_next = M_IDLE;
      end
      M_L_TAG: begin
        mode_next = M_L_FIELD;
        ndec      = LINE_FIELDS;
        fld       = (in_byte != CH_BAR);
      end
      M_C_TAG: begin
        mode_next = M_C_FIELD;
        ndec      = CIRCLE_FIELDS;
        fld       = (in_byte != CH_BAR);
      end
      M_L_FIELD: begin
        ndec = LINE_FIELDS;
        fld  = 1'b1;
      end
      M_C_FIELD: begin
        ndec = CIRCLE_FIELDS;
        fld  = 1'b1;
      end
      M_P_TAG: begin
        if (in_byte == CH_BAR) begin
          mode_next = M_P_START;
        end else begin
          mode_next = M_P_FIELD;
          fld       = 1'b1;
        end
      end
      M_P_START: begin
        if (in_byte == CH_BAR) begin
          // A bar where a point would start closes the polygon.
          emit        = 1'b1;
          result.kind = KIND_END;
          clr_post    = 1'b1;
          mode_next   = M_IDLE;
        end else begin
          clr_pre   = 1'b1;
          mode_next = M_P_FIELD;
          fld       = 1'b1;
        end
      end
      M_P_FIELD: begin
        fld = 1'b1;
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase

    // Starting values, cleared when a record or a point begins.
    for (int i = 0; i < 4; i++) begin
      acc_next[i] = clr_pre ? '0 : acc[i];
    end
    field_index_next = clr_pre ? '0 : field_index;
    colour_acc_next  = clr_pre ? '0 : colour_acc;

    // One byte of a field-bearing record.
    if (fld) begin
      if (field_index_next < ndec) begin
        if (in_byte == CH_COMMA) begin
          field_index_next = field_index_next + 3'd1;
        end else begin
          acc_next[field_index_next[1:0]] = (acc_next[field_index_next[1:0]] << 3)
              + (acc_next[field_index_next[1:0]] << 1)
              + VALUE_WIDTH'(in_byte) - VALUE_WIDTH'(CH_ZERO);
        end
      end else if (ndec == POLY_FIELDS && (in_byte == CH_SEMI || in_byte == CH_BAR)) begin
        last              = (in_byte == CH_BAR);
        emit              = 1'b1;
        result.kind       = KIND_POINT;
        result.first_x    = out_val(acc_next[0]);
        result.first_y    = out_val(acc_next[1]);
        result.colour     = colour_acc_next;
        result.last_point = last;
        clr_post          = 1'b1;
        mode_next         = last ? M_IDLE : M_P_START;
      end else if (ndec != POLY_FIELDS && in_byte == CH_BAR) begin
        emit                = 1'b1;
        result.kind         = (ndec == LINE_FIELDS) ? KIND_LINE : KIND_CIRCLE;
        result.first_x      = out_val(acc_next[0]);
        result.first_y      = out_val(acc_next[1]);
        result.second_value = out_val(acc_next[2]);
        result.second_y     = (ndec == LINE_FIELDS) ? out_val(acc_next[3]) : '0;
        result.colour       = colour_acc_next;
        clr_post            = 1'b1;
        mode_next           = M_IDLE;
      end else begin
        colour_acc_next = (colour_acc_next << 4) + hex_digit(in_byte);
      end
    end

    // Clear after a result.
    if (clr_post) begin
      for (int i = 0; i < 4; i++) begin
        acc_next[i] = '0;
      end
      field_index_next = '0;
      colour_acc_next  = '0;
    end
  end

  // Mode, index, accumulator and colour registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      field_index <= '0;
      colour_acc  <= '0;
      for (int i = 0; i < 4; i++) begin
        acc[i] <= '0;
      end
    end else if (step) begin
      mode        <= mode_next;
      field_index <= field_index_next;
      colour_acc  <= colour_acc_next;
      for (int i = 0; i < 4; i++) begin
        acc[i] <= acc_next[i];
      end
    end
  end

endmodule

/* rtl/shape_record_text_parser.sv */
// Top level of the shape record text parser: byte input register, parser core, result register.
//
//   channel  | dir | beat contents
//   s_axis   | in  | tdata[7:0] in_byte
//   m_axis   | out | tdata first_x, first_y, second_value, second_y, colour;
//            |     | tuser kind; tlast last_point
//
// One byte is taken per cycle unless a full result register stalls the input. The byte that
// closes a record waits in the input register; its result is loaded into the result register
// as that byte moves on into the core. The parser core updates its state only when the byte
// in the input register moves on, which happens when the result register is empty or being
// drained. m_axis_tready reaches s_axis_tready through that one gate.
// Reset is synchronous and clears all parser state and both valid flags.
module shape_record_text_parser import srtp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] in_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] first_x, [63:32] first_y, [95:64] second_value, [127:96] second_y,
  // [159:128] colour
  output logic [159:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,  // [1:0] kind
  output logic         m_axis_tlast
);

  logic    in_valid;
  char_t   in_byte;
  logic    advance;
  logic    emit;
  result_t core_result;
  logic    out_valid;
  result_t out_result;

  // The input byte moves into the core when the result slot can take a result.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  srtp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .emit    (emit),
    .result  (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_result.colour, out_result.second_y, out_result.second_value,
                          out_result.first_y, out_result.first_x};
  assign m_axis_tuser  = out_result.kind;
  assign m_axis_tlast  = out_result.last_point;

`ifndef SYNTH
  // An end marker carries no coordinates or colour and is never flagged last.
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("end marker with payload");

  // Only polygon points can be flagged last.
  a_last_point: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_POINT)
    else $error("last flag on a non-point beat");

  // Only lines carry a second y.
  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_LINE |-> m_axis_tdata[127:96] == '0)
    else $error("second y on a non-line beat");

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");
`endif

endmodule

/* tb/shape_record_checker.sv */
`timescale 1ns / 1ps
// Checker for the shape record parser: watches both streams, predicts results and compares them.
module shape_record_checker import srtp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [159:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           errors,
  output int           pending,
  output int           checked
);

  // Parser state as the predictor sees it.
  mode_t      mode;
  logic [2:0] fld;
  value_t     acc [4];
  word_t      colour;

  // Records and points still owed by the block, oldest first.
  result_t    owed_records [$];

  // Decimal fields leave the block sign-extended or cut to the output word.
  function automatic word_t widen(input value_t v);
    return word_t'(longint'($signed(v)));
  endfunction

  // Value of one colour character; anything that is not a hex letter counts from '0'.
  function automatic word_t colour_nibble(input char_t b);
    if (b >= "a" && b <= "f") begin
      return word_t'(b - "a") + word_t'(10);
    end else if (b >= "A" && b <= "F") begin
      return word_t'(b - "A") + word_t'(10);
    end
    return word_t'(b) - word_t'(CH_ZERO);
  endfunction

  task automatic clear_fields();
    for (int i = 0; i < 4; i++) acc[i] = '0;
    colour = '0;
    fld = '0;
  endtask

  task automatic owe_record(input logic [1:0] k, input value_t fx, input value_t fy,
                            input value_t sv, input value_t sy, input word_t col,
                            input logic last);
    result_t r;
    r.kind = k;
    r.first_x = widen(fx);
    r.first_y = widen(fy);
    r.second_value = widen(sv);
    r.second_y = widen(sy);
    r.colour = col;
    r.last_point = last;
    owed_records.push_back(r);
  endtask

  // One character inside a record that carries fields; mode is already the field mode.
  task automatic field_char(input char_t b, input logic [2:0] nfields);
    if (fld < nfields) begin
      if (b == CH_COMMA) begin
        fld = fld + 3'd1;
      end else begin
        acc[fld[1:0]] = acc[fld[1:0]] * value_t'(10) + value_t'(b) - value_t'(CH_ZERO);
      end
    end else if (mode == M_P_FIELD && (b == CH_SEMI || b == CH_BAR)) begin
      owe_record(KIND_POINT, acc[0], acc[1], '0, '0, colour, b == CH_BAR);
      clear_fields();
      mode = (b == CH_BAR) ? M_IDLE : M_P_START;
    end else if (mode != M_P_FIELD && b == CH_BAR) begin
      if (mode == M_L_FIELD) begin
        owe_record(KIND_LINE, acc[0], acc[1], acc[2], acc[3], colour, 1'b0);
      end else begin
        owe_record(KIND_CIRCLE, acc[0], acc[1], acc[2], '0, colour, 1'b0);
      end
      clear_fields();
      mode = M_IDLE;
    end else begin
      colour = colour * word_t'(16) + colour_nibble(b);
    end
  endtask

  // Advance the predicted parser by one accepted character.
  task automatic parse_char(input char_t b);
    case (mode)
      M_IDLE: begin
        if (b == CH_HASH) begin
          mode = M_COMMENT;
        end else if (b == CH_L_UP || b == CH_L_LOW) begin
          clear_fields();
          mode = M_L_TAG;
        end else if (b == CH_C_UP || b == CH_C_LOW) begin
          clear_fields();
          mode = M_C_TAG;
        end else if (b == CH_P_UP || b == CH_P_LOW) begin
          clear_fields();
          mode = M_P_TAG;
        end
      end
      M_COMMENT: begin
        if (b == CH_NEWLINE) mode = M_IDLE;
      end
      M_L_TAG: begin
        mode = M_L_FIELD;
        if (b != CH_BAR) field_char(b, LINE_FIELDS);
      end
      M_C_TAG: begin
        mode = M_C_FIELD;
        if (b != CH_BAR) field_char(b, CIRCLE_FIELDS);
      end
      M_L_FIELD: field_char(b, LINE_FIELDS);
      M_C_FIELD: field_char(b, CIRCLE_FIELDS);
      M_P_TAG: begin
        if (b == CH_BAR) begin
          mode = M_P_START;
        end else begin
          mode = M_P_FIELD;
          field_char(b, POLY_FIELDS);
        end
      end
      M_P_START: begin
        // A bar where a point would begin closes the polygon with an end marker.
        if (b == CH_BAR) begin
          owe_record(KIND_END, '0, '0, '0, '0, '0, 1'b0);
          clear_fields();
          mode = M_IDLE;
        end else begin
          clear_fields();
          mode = M_P_FIELD;
          field_char(b, POLY_FIELDS);
        end
      end
      M_P_FIELD: field_char(b, POLY_FIELDS);
      default: mode = M_IDLE;
    endcase
  endtask

  task automatic compare(input string what, input word_t want, input word_t got);
    if (got !== want) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
    end
  endtask

  task automatic check_beat();
    result_t want;
    if (owed_records.size() == 0) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: result beat with nothing expected, expected none, actual kind %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end
      return;
    end
    want = owed_records.pop_front();
    checked++;
    compare("kind", word_t'(want.kind), word_t'(m_axis_tuser));
    compare("first_x", want.first_x, m_axis_tdata[31:0]);
    compare("first_y", want.first_y, m_axis_tdata[63:32]);
    compare("second_value", want.second_value, m_axis_tdata[95:64]);
    compare("second_y", want.second_y, m_axis_tdata[127:96]);
    compare("colour", want.colour, m_axis_tdata[159:128]);
    compare("last_point", word_t'(want.last_point), word_t'(m_axis_tlast));
  endtask

  // Results are checked before the new byte is parsed; the block never answers in the same cycle.
  always @(posedge clk) begin
    if (rst) begin
      mode = M_IDLE;
      clear_fields();
      owed_records.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (s_axis_tvalid && s_axis_tready) parse_char(s_axis_tdata);
    end
    pending = owed_records.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, scene text stimulus, output stalls and the verdict.
module testbench;
  import srtp_pkg::*;

  localparam int TARGET_CHARS = 1050;
  localparam int CALM_TAIL    = 150;
  localparam int STALL_LIMIT  = 1000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int errors;
  int pending;
  int checked;
  int chars_sent = 0;
  int chars_ignored = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;

  shape_record_text_parser dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  shape_record_checker checker_inst (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors, .pending, .checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls in short random bursts while gaps are enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= !rst;
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still owed", $time, quiet_cycles,
               pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one character and hold it until the parser takes it.
  task automatic send_char(input char_t b);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Mostly decimal digits, now and then any byte that does not end the field.
  function automatic char_t decimal_char();
    char_t b;
    if ($urandom_range(0, 9) != 0) return CH_ZERO + char_t'($urandom_range(0, 9));
    b = CH_COMMA;
    while (b == CH_COMMA) b = char_t'($urandom_range(0, 255));
    return b;
  endfunction

  // A decimal field and its comma; long fields wrap the accumulator.
  task automatic put_decimal();
    int n;
    case ($urandom_range(0, 9))
      0: n = 0;
      1, 2: n = $urandom_range(5, 12);
      default: n = $urandom_range(1, 4);
    endcase
    repeat (n) send_char(decimal_char());
    send_char(CH_COMMA);
  endtask

  // Hex colour of either case, sometimes long enough to wrap, with the odd stray byte.
  task automatic put_colour(input bit poly);
    string hexset = "0123456789abcdefABCDEF";
    int n;
    char_t b;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0) begin
        b = CH_BAR;
        while (b == CH_BAR || (poly && b == CH_SEMI)) b = char_t'($urandom_range(0, 255));
      end else begin
        b = hexset[$urandom_range(0, 21)];
      end
      send_char(b);
    end
  endtask

  // Line or circle record: tag, optional bar, decimal fields, colour, closing bar.
  task automatic put_shape(input char_t up, input char_t low, input logic [2:0] nfields);
    send_char($urandom_range(0, 1) ? up : low);
    if ($urandom_range(0, 1)) send_char(CH_BAR);
    repeat (nfields) put_decimal();
    put_colour(1'b0);
    send_char(CH_BAR);
  endtask

  // Polygon: zero to four points, closed by a bar on the last point or by an end marker.
  task automatic put_polygon();
    int npts;
    npts = $urandom_range(0, 4);
    send_char($urandom_range(0, 1) ? CH_P_UP : CH_P_LOW);
    if (npts == 0 || $urandom_range(0, 1)) send_char(CH_BAR);
    for (int i = 0; i < npts; i++) begin
      put_decimal();
      put_decimal();
      put_colour(1'b1);
      if (i < npts - 1) begin
        send_char(CH_SEMI);
      end else if ($urandom_range(0, 1)) begin
        send_char(CH_BAR);
      end else begin
        send_char(CH_SEMI);
        send_char(CH_BAR);
      end
    end
    if (npts == 0) send_char(CH_BAR);
  endtask

  // Comment line or a few stray bytes at top level.
  task automatic put_filler();
    int n;
    char_t b;
    n = $urandom_range(1, 10);
    if ($urandom_range(0, 1)) begin
      send_char(CH_HASH);
      repeat (n) begin
        b = CH_NEWLINE;
        while (b == CH_NEWLINE) b = char_t'($urandom_range(0, 255));
        send_char(b);
      end
      send_char(CH_NEWLINE);
      chars_ignored += n + 2;
    end else begin
      repeat (n % 4 + 1) begin
        b = CH_HASH;
        while (b == CH_HASH) b = char_t'($urandom_range(0, 255));
        send_char(b);
        chars_ignored++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a tag hidden in a comment, a line with extreme bytes in empty-ish
    // fields, a circle with a bar after the tag and separators taken as digits, and a
    // polygon point followed by an end marker.
    send_text("#p\n");
    send_char(CH_L_UP);
    send_char(8'h00);
    send_text(",,");
    send_char(8'hFF);
    send_text(",F|");
    send_text("c|7,;,a,;|");
    send_text("P1,2,f;|");
    chars_ignored += 3;

    // Random part: mostly well-formed records with random content, some filler.
    while (chars_sent < TARGET_CHARS) begin
      if (chars_sent > TARGET_CHARS - CALM_TAIL) gaps_on = 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: put_shape(CH_L_UP, CH_L_LOW, LINE_FIELDS);
        5, 6, 7, 8, 9: put_shape(CH_C_UP, CH_C_LOW, CIRCLE_FIELDS);
        10, 11, 12, 13, 14, 15: put_polygon();
        default: put_filler();
      endcase
    end
    s_axis_tvalid <= 1'b0;

    // Drain what is still owed before the verdict.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d text bytes, %0d of them inside records; %0d results compared.",
             chars_sent, chars_sent - chars_ignored, checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
